// ----- sv/rsas_pkg.sv -----
// Package: shared types, constants and command codes of the rotated sorted array search core.
package rsas_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 10;
  localparam int DEPTH_DEFAULT = 1024;

  typedef struct packed {
    logic                     mode;
    logic                     first_element;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] search_key;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic [IDX_W-1:0] pivot_index;
  } result_t;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CAP_FIRST,
    S_CAP_LAST,
    S_PIV_CHECK,
    S_PIV_STEP,
    S_SET_RANGE,
    S_BS_CHECK,
    S_BS_STEP,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_CAP_FIRST,
    OP_CAP_LAST,
    OP_PIV_STEP,
    OP_SET_RANGE,
    OP_BS_STEP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_MID,
    ADDR_LO
  } addr_sel_t;

  typedef struct packed {
    op_t       op;
    logic      rd_en;
    addr_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic lo_lt_hi;
    logic lo_le_hi;
    logic hit;
  } status_t;

endpackage

// ----- sv/rsas_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module rsas_ram #(
  parameter int WIDTH = rsas_pkg::DATA_W,
  parameter int DEPTH = rsas_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/rsas_ctrl.sv -----
// Controller: sequences loads, the pivot search and the key search over the datapath.
module rsas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  input  rsas_pkg::status_t status,
  output logic              busy,
  output rsas_pkg::cmd_t    cmd
);

  rsas_pkg::state_t state, state_next;
  logic             accept;

  assign accept = start && (state == rsas_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsas_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rsas_pkg::S_IDLE: begin
        if (accept && mode == rsas_pkg::MODE_SEARCH) begin
          state_next = status.empty ? rsas_pkg::S_EMIT : rsas_pkg::S_RD_FIRST;
        end
      end
      rsas_pkg::S_RD_FIRST:  state_next = rsas_pkg::S_CAP_FIRST;
      rsas_pkg::S_CAP_FIRST: state_next = rsas_pkg::S_CAP_LAST;
      rsas_pkg::S_CAP_LAST:  state_next = rsas_pkg::S_PIV_CHECK;
      rsas_pkg::S_PIV_CHECK: begin
        state_next = status.lo_lt_hi ? rsas_pkg::S_PIV_STEP : rsas_pkg::S_SET_RANGE;
      end
      rsas_pkg::S_PIV_STEP:  state_next = rsas_pkg::S_PIV_CHECK;
      rsas_pkg::S_SET_RANGE: state_next = rsas_pkg::S_BS_CHECK;
      rsas_pkg::S_BS_CHECK: begin
        state_next = status.lo_le_hi ? rsas_pkg::S_BS_STEP : rsas_pkg::S_EMIT;
      end
      rsas_pkg::S_BS_STEP: begin
        state_next = status.hit ? rsas_pkg::S_EMIT : rsas_pkg::S_BS_CHECK;
      end
      rsas_pkg::S_EMIT:      state_next = rsas_pkg::S_IDLE;
      default:               state_next = rsas_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = rsas_pkg::OP_NONE;
    cmd.rd_en  = 1'b0;
    cmd.rd_sel = rsas_pkg::ADDR_ZERO;
    busy       = (state != rsas_pkg::S_IDLE);
    unique case (state)
      rsas_pkg::S_IDLE: begin
        if (accept) begin
          cmd.op = (mode == rsas_pkg::MODE_SEARCH) ? rsas_pkg::OP_INIT : rsas_pkg::OP_LOAD;
        end
      end
      rsas_pkg::S_RD_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = rsas_pkg::ADDR_ZERO;
      end
      rsas_pkg::S_CAP_FIRST: begin
        cmd.op     = rsas_pkg::OP_CAP_FIRST;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = rsas_pkg::ADDR_LAST;
      end
      rsas_pkg::S_CAP_LAST: cmd.op = rsas_pkg::OP_CAP_LAST;
      rsas_pkg::S_PIV_CHECK: begin
        // probe mid while the range is open, else fetch the pivot element
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = status.lo_lt_hi ? rsas_pkg::ADDR_MID : rsas_pkg::ADDR_LO;
      end
      rsas_pkg::S_PIV_STEP:  cmd.op = rsas_pkg::OP_PIV_STEP;
      rsas_pkg::S_SET_RANGE: cmd.op = rsas_pkg::OP_SET_RANGE;
      rsas_pkg::S_BS_CHECK: begin
        cmd.rd_en  = status.lo_le_hi;
        cmd.rd_sel = rsas_pkg::ADDR_MID;
      end
      rsas_pkg::S_BS_STEP:   cmd.op = rsas_pkg::OP_BS_STEP;
      rsas_pkg::S_EMIT:      cmd.op = rsas_pkg::OP_EMIT;
      default:               cmd.op = rsas_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- sv/rsas_dp.sv -----
// Datapath: element store, element count, search bounds, compares and result register.
module rsas_dp #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  rsas_pkg::cmd_t    cmd,
  input  rsas_pkg::item_t   item,
  output rsas_pkg::status_t status,
  output logic              done,
  output rsas_pkg::result_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;
  localparam int OW = rsas_pkg::IDX_W;
  localparam int DW = rsas_pkg::DATA_W;
  localparam logic signed [IW-1:0] ONE = 1;

  logic [CW-1:0]           count;
  logic signed [DW-1:0]    key;
  logic signed [DW-1:0]    e0;
  logic signed [DW-1:0]    elast;
  logic signed [IW-1:0]    lo;
  logic signed [IW-1:0]    hi;
  logic signed [IW-1:0]    mid;
  logic signed [IW-1:0]    n_last;
  logic [AW-1:0]           pivot;
  logic [AW-1:0]           idx;
  logic                    found_r;
  logic signed [DW-1:0]    rdata_s;
  logic [DW-1:0]           rd_data;
  logic [AW-1:0]           rd_addr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic                    in_upper;

  assign mid      = lo + ((hi - lo) >>> 1);
  assign n_last   = $signed(IW'(count)) - ONE;
  assign rdata_s  = $signed(rd_data);
  assign in_upper = (key >= rdata_s) && (key <= elast);

  assign status.empty    = (count == '0);
  assign status.lo_lt_hi = (lo < hi);
  assign status.lo_le_hi = (lo <= hi);
  assign status.hit      = (rdata_s == key);

  always_comb begin
    unique case (cmd.rd_sel)
      rsas_pkg::ADDR_ZERO: rd_addr = '0;
      rsas_pkg::ADDR_LAST: rd_addr = n_last[AW-1:0];
      rsas_pkg::ADDR_MID:  rd_addr = mid[AW-1:0];
      rsas_pkg::ADDR_LO:   rd_addr = lo[AW-1:0];
      default:             rd_addr = '0;
    endcase
  end

  // full store drops plain loads; a restart always lands at index zero
  assign we    = (cmd.op == rsas_pkg::OP_LOAD) &&
                 (item.first_element || (count < CW'(DEPTH)));
  assign waddr = item.first_element ? '0 : count[AW-1:0];

  rsas_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.element_value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (cmd.op == rsas_pkg::OP_EMIT);
      if (cmd.op == rsas_pkg::OP_LOAD) begin
        if (item.first_element) begin
          count <= CW'(1);
        end else if (count < CW'(DEPTH)) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rsas_pkg::OP_INIT: begin
        key     <= item.search_key;
        lo      <= '0;
        hi      <= n_last;
        pivot   <= '0;
        idx     <= '0;
        found_r <= 1'b0;
      end
      rsas_pkg::OP_CAP_FIRST: e0    <= rdata_s;
      rsas_pkg::OP_CAP_LAST:  elast <= rdata_s;
      rsas_pkg::OP_PIV_STEP: begin
        if (rdata_s >= e0) begin
          lo <= mid + ONE;
        end else begin
          hi <= mid;
        end
      end
      rsas_pkg::OP_SET_RANGE: begin
        // rd_data holds the pivot element here
        pivot <= lo[AW-1:0];
        if (in_upper) begin
          hi <= n_last;
        end else begin
          lo <= '0;
          hi <= lo - ONE;
        end
      end
      rsas_pkg::OP_BS_STEP: begin
        if (rdata_s == key) begin
          found_r <= 1'b1;
          idx     <= mid[AW-1:0];
        end else if (rdata_s < key) begin
          lo <= mid + ONE;
        end else begin
          hi <= mid - ONE;
        end
      end
      rsas_pkg::OP_EMIT: begin
        result.found       <= found_r;
        result.match_index <= OW'(idx);
        result.pivot_index <= OW'(pivot);
      end
      default: begin
      end
    endcase
  end

  a_done_follows_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.op == rsas_pkg::OP_EMIT))
    else $error("result strobe without emit command");

  a_piv_step_open_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rsas_pkg::OP_PIV_STEP) |-> (lo < hi))
    else $error("pivot step on a closed range");

  a_bs_probe_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rsas_pkg::OP_BS_STEP) |-> (lo <= hi) && (mid >= 0) &&
      (mid < $signed(IW'(count))))
    else $error("key probe outside the loaded elements");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond capacity");

endmodule

// ----- sv/rotated_sorted_array_search_core.sv -----
// Top level of the rotated sorted array search core: controller plus datapath.
//
// A transaction is taken at a rising edge with start high and busy low. A load
// transaction (mode 0) writes its element into the store in that same edge and
// leaves busy low, so loads can stream one per cycle; first_element restarts the
// array at index zero, and plain loads past DEPTH entries are dropped. A search
// transaction (mode 1) raises busy and walks the single read port of the element
// store: two reads for the first and last elements, then one probe (address,
// then compare) per pivot-search step and per key-search step. An empty array
// skips the reads and goes straight to the result. The result register is
// updated and done is high for exactly one cycle, in the same cycle that busy
// drops; there is no way to hold it off, so capture it when done is high. A new
// transaction may be started in that same cycle. Index outputs carry the low 10
// bits of the index, and match_index is zero when the key is not found.
module rotated_sorted_array_search_core #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rsas_pkg::item_t   item,
  output logic              done,
  output rsas_pkg::result_t result
);

  rsas_pkg::cmd_t    cmd;
  rsas_pkg::status_t status;

  // Sequencer: owns busy and issues one command per cycle.
  rsas_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (item.mode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Store, bounds registers and result register.
  rsas_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
